### hw/rtl/svs_pkg.sv
// Shared types, codes and helper functions of the spherical voxel store.
`timescale 1ns / 1ps

package svs_pkg;

   localparam int DefMaxRadius = 7;
   localparam int DefVoxelBits = 32;

   localparam int RadiusBits = 3;
   localparam int CoordBits  = 5;
   localparam int GridBits   = 4;
   localparam int PartBits   = 8;
   localparam int IndexBits  = 12;
   localparam int WordBits   = 32;
   localparam int CountBits  = 12;

   localparam logic [RadiusBits-1:0] ResetRadius = 3'd7;
   localparam logic [CountBits-1:0]  CountMax    = 12'd4095;

   localparam int QueueDepth = 2;
   localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntBits   = $clog2(QueueDepth + 1);

   localparam logic [2:0] OP_READ_GRID    = 3'd0;
   localparam logic [2:0] OP_WRITE_GRID   = 3'd1;
   localparam logic [2:0] OP_READ_OFFSET  = 3'd2;
   localparam logic [2:0] OP_WRITE_OFFSET = 3'd3;
   localparam logic [2:0] OP_COUNT        = 3'd4;

   typedef logic signed [GridBits-1:0] offset_type;

   typedef enum logic [1:0] {
      KIND_READ,
      KIND_WRITE,
      KIND_COUNT,
      KIND_REFUSE
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [PartBits-1:0]   part;
      logic [GridBits-1:0]   gx;
      logic [WordBits-1:0]   wdata;
   } entry_type;

   function automatic logic [GridBits-1:0] side_of(logic [RadiusBits-1:0] r);
      return {r, 1'b1};
   endfunction

   function automatic logic [5:0] square3(logic [2:0] a);
      return {3'b000, a} * {3'b000, a};
   endfunction

   function automatic logic in_sphere(offset_type dx, offset_type dy, offset_type dz,
                                      logic [RadiusBits-1:0] r);
      logic [2:0] ax;
      logic [2:0] ay;
      logic [2:0] az;
      logic [7:0] sum;
      ax = dx[GridBits-1] ? 3'(-dx) : dx[2:0];
      ay = dy[GridBits-1] ? 3'(-dy) : dy[2:0];
      az = dz[GridBits-1] ? 3'(-dz) : dz[2:0];
      sum = {2'b00, square3(ax)} + {2'b00, square3(ay)} + {2'b00, square3(az)};
      return sum <= {2'b00, square3(r)};
   endfunction

endpackage

### hw/rtl/svs_queue.sv
// Short queue of classified operations between front and back.
`timescale 1ns / 1ps

module svs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  svs_pkg::entry_type  push_entry,
   output logic                full,
   output logic                head_valid,
   output svs_pkg::entry_type  head,
   input  logic                pop
);
   import svs_pkg::*;

   entry_type              slot_ff [QueueDepth];
   logic [QPtrBits-1:0]    wr_ptr_ff;
   logic [QPtrBits-1:0]    wr_ptr_in;
   logic [QPtrBits-1:0]    rd_ptr_ff;
   logic [QPtrBits-1:0]    rd_ptr_in;
   logic [QCntBits-1:0]    count_ff;
   logic [QCntBits-1:0]    count_in;

   assign full       = (count_ff == QCntBits'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/svs_front.sv
// Front end: accepts request words and checks coordinates against cube and sphere.
`timescale 1ns / 1ps

module svs_front (
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_opcode,
   input  logic signed [svs_pkg::CoordBits-1:0] req_coord_x,
   input  logic signed [svs_pkg::CoordBits-1:0] req_coord_y,
   input  logic signed [svs_pkg::CoordBits-1:0] req_coord_z,
   input  logic [svs_pkg::WordBits-1:0]       req_write_data,
   input  logic [svs_pkg::RadiusBits-1:0]     radius,
   input  logic                               back_busy,
   input  logic                               queue_full,
   output logic                               push,
   output svs_pkg::entry_type                 push_entry
);
   import svs_pkg::*;

   logic [GridBits-1:0]   side;
   logic signed [5:0]     gx6;
   logic signed [5:0]     gy6;
   logic signed [5:0]     gz6;
   logic [5:0]            bias;
   logic                  in_cube;
   logic                  in_ball;
   logic [GridBits-1:0]   gx;
   logic [GridBits-1:0]   gy;
   logic [GridBits-1:0]   gz;
   offset_type            dx;
   offset_type            dy;
   offset_type            dz;

   assign side = side_of(radius);
   assign bias = (req_opcode == OP_READ_OFFSET || req_opcode == OP_WRITE_OFFSET) ?
                 {3'b000, radius} : 6'd0;

   assign gx6 = $signed({req_coord_x[CoordBits-1], req_coord_x}) + $signed(bias);
   assign gy6 = $signed({req_coord_y[CoordBits-1], req_coord_y}) + $signed(bias);
   assign gz6 = $signed({req_coord_z[CoordBits-1], req_coord_z}) + $signed(bias);

   assign in_cube = !gx6[5] && (gx6[4:0] < {1'b0, side})
                 && !gy6[5] && (gy6[4:0] < {1'b0, side})
                 && !gz6[5] && (gz6[4:0] < {1'b0, side});

   assign gx = gx6[GridBits-1:0];
   assign gy = gy6[GridBits-1:0];
   assign gz = gz6[GridBits-1:0];

   assign dx = offset_type'(gx - {1'b0, radius});
   assign dy = offset_type'(gy - {1'b0, radius});
   assign dz = offset_type'(gz - {1'b0, radius});

   assign in_ball = in_cube && in_sphere(dx, dy, dz, radius);

   assign req_ready = !queue_full && !back_busy;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_entry.part  = {4'b0000, gz} * {4'b0000, side} + {4'b0000, gy};
      push_entry.gx    = gx;
      push_entry.wdata = req_write_data;
      case (req_opcode)
         OP_READ_GRID, OP_READ_OFFSET: begin
            push_entry.kind = in_ball ? KIND_READ : KIND_REFUSE;
         end
         OP_WRITE_GRID, OP_WRITE_OFFSET: begin
            push_entry.kind = in_ball ? KIND_WRITE : KIND_REFUSE;
         end
         OP_COUNT: begin
            push_entry.kind = KIND_COUNT;
         end
         default: begin
            push_entry.kind = KIND_REFUSE;
         end
      endcase
   end

endmodule

### hw/rtl/svs_back.sv
// Back end: voxel memory, clearing pass, count walk and response register.
`timescale 1ns / 1ps

module svs_back #(
   parameter int MAX_RADIUS = svs_pkg::DefMaxRadius,
   parameter int VOXEL_BITS = svs_pkg::DefVoxelBits
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [svs_pkg::RadiusBits-1:0]  radius,
   input  logic                            clear_start,
   output logic                            busy,
   input  logic                            head_valid,
   input  svs_pkg::entry_type              head,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [svs_pkg::WordBits-1:0]    rsp_read_data,
   output logic                            rsp_status,
   output logic [svs_pkg::CountBits-1:0]   rsp_valid_count
);
   import svs_pkg::*;

   localparam int Side      = 2 * MAX_RADIUS + 1;
   localparam int Depth     = Side * Side * Side;
   localparam int AddrBits  = $clog2(Depth);
   localparam logic [AddrBits-1:0] LastAddr = AddrBits'(Depth - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COUNT,
      ST_COUNT_OUT
   } state_type;

   logic [VOXEL_BITS-1:0]  mem [Depth];
   logic [VOXEL_BITS-1:0]  rd_word_ff;

   state_type              state_ff;
   state_type              state_in;
   logic [AddrBits-1:0]    clr_addr_ff;
   logic [AddrBits-1:0]    clr_addr_in;
   offset_type             dx_ff;
   offset_type             dx_in;
   offset_type             dy_ff;
   offset_type             dy_in;
   offset_type             dz_ff;
   offset_type             dz_in;
   logic [CountBits-1:0]   cnt_ff;
   logic [CountBits-1:0]   cnt_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [WordBits-1:0]    rsp_data_ff;
   logic [WordBits-1:0]    rsp_data_in;
   logic                   rsp_status_ff;
   logic                   rsp_status_in;
   logic [CountBits-1:0]   rsp_count_ff;
   logic [CountBits-1:0]   rsp_count_in;

   logic [GridBits-1:0]    side;
   logic [IndexBits-1:0]   index;
   logic [AddrBits-1:0]    acc_addr;
   logic                   out_free;
   logic                   mem_we;
   logic [AddrBits-1:0]    mem_waddr;
   logic [VOXEL_BITS-1:0]  mem_wdata;
   logic                   rd_en;
   offset_type             pos_r;
   offset_type             neg_r;

   assign side     = side_of(radius);
   assign index    = {4'b0000, head.part} * {8'b0000_0000, side} + {8'b0000_0000, head.gx};
   assign acc_addr = AddrBits'(index);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pos_r    = offset_type'({1'b0, radius});
   assign neg_r    = offset_type'(4'd0 - {1'b0, radius});

   assign busy            = (state_ff == ST_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_valid_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = acc_addr;
      mem_wdata     = VOXEL_BITS'(head.wdata);
      rd_en         = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               case (head.kind)
                  KIND_READ: begin
                     rd_en    = 1'b1;
                     state_in = ST_READ;
                  end
                  KIND_WRITE: begin
                     mem_we        = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = 1'b0;
                     rsp_count_in  = '0;
                  end
                  KIND_COUNT: begin
                     dx_in    = neg_r;
                     dy_in    = neg_r;
                     dz_in    = neg_r;
                     cnt_in   = '0;
                     state_in = ST_COUNT;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = 1'b1;
                     rsp_count_in  = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = WordBits'(rd_word_ff);
               rsp_status_in = 1'b0;
               rsp_count_in  = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_COUNT: begin
            if (in_sphere(dx_ff, dy_ff, dz_ff, radius) && cnt_ff != CountMax) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (dx_ff == pos_r) begin
               dx_in = neg_r;
               if (dy_ff == pos_r) begin
                  dy_in = neg_r;
                  if (dz_ff == pos_r) begin
                     state_in = ST_COUNT_OUT;
                  end else begin
                     dz_in = dz_ff + 1'b1;
                  end
               end else begin
                  dy_in = dy_ff + 1'b1;
               end
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         ST_COUNT_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = 1'b0;
               rsp_count_in  = cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (clear_start) begin
         state_in    = ST_CLEAR;
         clr_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dz_ff         <= dz_in;
      cnt_ff        <= cnt_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_word_ff <= mem[acc_addr];
      end
   end

endmodule

### hw/rtl/spherical_voxel_store.sv
// Top level of the spherical voxel store: radius register, front, queue and back.
//
//   channel  ports   direction  handshake
//   request  req_*   in         req_valid / req_ready
//   response rsp_*   out        rsp_valid / rsp_ready
//   config   csr_*   in         csr_write_enable, no wait
//
// Front takes one word per cycle into a two-entry queue while the queue has room and no
// clearing pass runs. Back answers a write or refused word straight from idle, a read
// through ST_READ (one registered memory port), and a count by walking the cube one
// voxel per cycle, then ST_COUNT_OUT. Reset and every radius write start a clearing pass
// over all (2*MAX_RADIUS+1)^3 memory words, one word per cycle, with req_ready low. A
// stalled response holds the back end; the front keeps filling the queue.
`timescale 1ns / 1ps

module spherical_voxel_store #(
   parameter int MAX_RADIUS = svs_pkg::DefMaxRadius,
   parameter int VOXEL_BITS = svs_pkg::DefVoxelBits
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [2:0]                           req_opcode,
   input  logic signed [svs_pkg::CoordBits-1:0] req_coord_x,
   input  logic signed [svs_pkg::CoordBits-1:0] req_coord_y,
   input  logic signed [svs_pkg::CoordBits-1:0] req_coord_z,
   input  logic [svs_pkg::WordBits-1:0]         req_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [svs_pkg::WordBits-1:0]         rsp_read_data,
   output logic                                 rsp_status,
   output logic [svs_pkg::CountBits-1:0]        rsp_valid_count,
   input  logic                                 csr_write_enable,
   input  logic [svs_pkg::RadiusBits-1:0]       csr_write_data
);
   import svs_pkg::*;

   localparam logic [RadiusBits:0] MaxRad = (RadiusBits + 1)'(MAX_RADIUS);

   logic [RadiusBits-1:0]  radius_ff;
   logic [RadiusBits-1:0]  radius_in;
   logic [RadiusBits-1:0]  radius;
   logic                   back_busy;
   logic                   queue_full;
   logic                   push;
   entry_type              push_entry;
   logic                   head_valid;
   entry_type              head;
   logic                   pop;

   assign radius_in = csr_write_enable ? csr_write_data : radius_ff;
   assign radius    = ({1'b0, radius_ff} > MaxRad) ? MaxRad[RadiusBits-1:0] : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ResetRadius;
      end else begin
         radius_ff <= radius_in;
      end
   end

   svs_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_write_data (req_write_data),
      .radius         (radius),
      .back_busy      (back_busy),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   svs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   svs_back #(
      .MAX_RADIUS (MAX_RADIUS),
      .VOXEL_BITS (VOXEL_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .radius          (radius),
      .clear_start     (csr_write_enable),
      .busy            (back_busy),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status),
      .rsp_valid_count (rsp_valid_count)
   );

endmodule

### verif/tb_spherical_voxel_store.sv
// Testbench for spherical_voxel_store: directed and random voxel traffic against a predictor.
`timescale 1ns / 1ps

module tb_spherical_voxel_store;
   import svs_pkg::*;

   localparam int SIDE_MAX  = 2 * DefMaxRadius + 1;
   localparam int CUBE_SIZE = SIDE_MAX * SIDE_MAX * SIDE_MAX;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam logic       STATUS_DONE    = 1'b0;
   localparam logic       STATUS_OUTSIDE = 1'b1;

   typedef struct packed {
      logic [WordBits-1:0]  read_data;
      logic                 status;
      logic [CountBits-1:0] valid_count;
   } voxel_reply_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [2:0]                  req_opcode = OP_READ_GRID;
   logic signed [CoordBits-1:0] req_coord_x = '0;
   logic signed [CoordBits-1:0] req_coord_y = '0;
   logic signed [CoordBits-1:0] req_coord_z = '0;
   logic [WordBits-1:0]         req_write_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [WordBits-1:0]         rsp_read_data;
   logic                        rsp_status;
   logic [CountBits-1:0]        rsp_valid_count;
   logic                        csr_write_enable = 1'b0;
   logic [RadiusBits-1:0]       csr_write_data = '0;

   logic [RadiusBits-1:0] model_radius;
   logic [WordBits-1:0]   voxel_mem [CUBE_SIZE];
   voxel_reply_type       replies_due [$];
   int                    mismatches = 0;
   bit                    no_idle = 1'b0;

   spherical_voxel_store uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_valid_count  (rsp_valid_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_voxels();
      foreach (voxel_mem[i]) voxel_mem[i] = '0;
   endfunction

   function automatic int voxel_slot(int gx, int gy, int gz);
      int r;
      int d;
      r = int'(model_radius);
      d = 2 * r + 1;
      if (gx < 0 || gx >= d || gy < 0 || gy >= d || gz < 0 || gz >= d) return -1;
      if ((gx - r) ** 2 + (gy - r) ** 2 + (gz - r) ** 2 > r * r) return -1;
      return (gz * d + gy) * d + gx;
   endfunction

   function automatic logic [CountBits-1:0] sphere_population();
      int r;
      int n;
      r = int'(model_radius);
      n = 0;
      for (int dz = -r; dz <= r; dz++)
         for (int dy = -r; dy <= r; dy++)
            for (int dx = -r; dx <= r; dx++)
               if (dx * dx + dy * dy + dz * dz <= r * r) n++;
      return (n > int'(CountMax)) ? CountMax : CountBits'(n);
   endfunction

   function automatic voxel_reply_type apply_voxel_op(logic [2:0] op, logic signed [4:0] cx,
                                                      logic signed [4:0] cy,
                                                      logic signed [4:0] cz,
                                                      logic [WordBits-1:0] wd);
      voxel_reply_type rep;
      int gx;
      int gy;
      int gz;
      int slot;
      rep = '{read_data: '0, status: STATUS_OUTSIDE, valid_count: '0};
      gx = int'(cx);
      gy = int'(cy);
      gz = int'(cz);
      if (op == OP_COUNT) begin
         rep.valid_count = sphere_population();
         rep.status = STATUS_DONE;
      end else if (op <= OP_WRITE_OFFSET) begin
         if (op == OP_READ_OFFSET || op == OP_WRITE_OFFSET) begin
            gx += int'(model_radius);
            gy += int'(model_radius);
            gz += int'(model_radius);
         end
         slot = voxel_slot(gx, gy, gz);
         if (slot >= 0) begin
            rep.status = STATUS_DONE;
            if (op == OP_WRITE_GRID || op == OP_WRITE_OFFSET) voxel_mem[slot] = wd;
            else rep.read_data = voxel_mem[slot];
         end
      end
      return rep;
   endfunction

   function automatic int gap_length();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(logic [2:0] op, logic signed [4:0] cx, logic signed [4:0] cy,
                            logic signed [4:0] cz, logic [WordBits-1:0] wd);
      int gap;
      gap = no_idle ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_coord_x    <= cx;
      req_coord_y    <= cy;
      req_coord_z    <= cz;
      req_write_data <= wd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      replies_due.push_back(apply_voxel_op(op, cx, cy, cz, wd));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_radius(logic [RadiusBits-1:0] r);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= r;
      model_radius = r;
      clear_voxels();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // pick one axis: most often near the center, often anywhere in the cube, sometimes noise
   function automatic logic signed [4:0] pick_axis(logic offset_form);
      int r;
      int s;
      int v;
      int k;
      r = int'(model_radius);
      s = (r < 2) ? r : 2;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         v = $urandom_range(0, 2 * s);
         v = v - s;
      end else if (k < 85) begin
         v = $urandom_range(0, 2 * r);
         v = v - r;
      end else begin
         v = $urandom_range(0, 31);
         return 5'(v - 16);
      end
      if (!offset_form) v += r;
      return 5'(v);
   endfunction

   task automatic send_random_word();
      logic [2:0] op;
      int k;
      k = $urandom_range(0, 99);
      if (k < 2) op = OP_COUNT;
      else if (k < 6) op = 3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
      else op = 3'($urandom_range(int'(OP_READ_GRID), int'(OP_WRITE_OFFSET)));
      send_word(op, pick_axis(op[1]), pick_axis(op[1]), pick_axis(op[1]), $urandom());
   endtask

   task automatic test_directed_edges();
      send_word(OP_COUNT, 0, 0, 0, '0);
      send_word(OP_READ_GRID, 7, 7, 7, '0);
      send_word(OP_WRITE_GRID, 0, 7, 7, 32'hFFFF_FFFF);
      send_word(OP_READ_GRID, 0, 7, 7, '0);
      send_word(OP_WRITE_OFFSET, 7, 0, 0, 32'hA5A5_5A5A);
      send_word(OP_READ_GRID, 14, 7, 7, '0);
      send_word(OP_WRITE_OFFSET, -7, 0, 0, '0);
      send_word(OP_READ_OFFSET, -7, 0, 0, '0);
      send_word(OP_WRITE_GRID, 0, 0, 0, 32'h1234_5678);
      send_word(OP_WRITE_GRID, -1, 7, 7, 32'h1111_1111);
      send_word(OP_READ_GRID, 15, 7, 7, '0);
      send_word(OP_WRITE_OFFSET, 8, 0, 0, 32'h2222_2222);
      send_word(OP_READ_OFFSET, -16, -16, -16, '0);
      send_word(OP_READ_OFFSET, 15, 15, 15, '0);
      send_word(OP_WRITE_OFFSET, 4, 4, 4, 32'hDEAD_BEEF);
      send_word(OP_READ_GRID, 11, 11, 11, '0);
      send_word(OP_WRITE_OFFSET, 4, 4, 5, 32'h3333_3333);
      send_word(OP_READ_OFFSET, 0, -7, 0, '0);
      send_word(OP_READ_GRID, 7, 7, 0, '0);
   endtask

   task automatic test_spare_opcodes();
      for (int op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++)
         send_word(3'(op), 0, 0, 0, 32'hFFFF_FFFF);
   endtask

   task automatic test_radius_clear();
      send_word(OP_WRITE_OFFSET, 0, 0, 0, 32'hC0FF_EE00);
      write_radius(3'd7);
      send_word(OP_READ_OFFSET, 0, 0, 0, '0);
      write_radius(3'd0);
      send_word(OP_COUNT, 0, 0, 0, '0);
      send_word(OP_WRITE_GRID, 0, 0, 0, 32'h0BAD_F00D);
      send_word(OP_READ_OFFSET, 0, 0, 0, '0);
      send_word(OP_READ_GRID, 1, 0, 0, '0);
      send_word(OP_WRITE_OFFSET, 1, 0, 0, 32'h4444_4444);
      send_word(OP_READ_GRID, 0, 0, 0, '0);
   endtask

   task automatic test_random_traffic();
      logic [RadiusBits-1:0] plan [8];
      plan = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd4};
      foreach (plan[p]) begin
         write_radius(plan[p]);
         for (int i = 0; i < 250; i++) begin
            no_idle = (i >= 100 && i < 150);
            send_random_word();
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin : drain_side
      int n;
      forever begin
         @(posedge clock);
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 24);
         repeat (n - 1) @(posedge clock);
         n = no_idle ? 0 : gap_length();
         if (n > 0) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      voxel_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $error("unexpected word: read_data %h status %b valid_count %0d",
                   rsp_read_data, rsp_status, rsp_valid_count);
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %b, got %b", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_valid_count !== want.valid_count) begin
               $error("valid_count: expected %0d, got %0d", want.valid_count, rsp_valid_count);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("FAIL spherical_voxel_store");
      $finish;
   end

   initial begin
      model_radius = ResetRadius;
      clear_voxels();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_spare_opcodes();
      test_radius_clear();
      test_random_traffic();
      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("PASS spherical_voxel_store");
      end else begin
         $display("FAIL spherical_voxel_store");
      end
      $finish;
   end

endmodule
